// File: rtl/core/hsem_pkg.sv
// hsem_pkg: shared types, constants and region table for the hue to six-emitter mix
// holds the channel specs per hue region and the reciprocal multipliers for the ramps
// no dependencies
package hsem_pkg;

  localparam int NUM_CH    = 6;
  localparam int HUE_W     = 16;
  localparam int LEVEL_W   = 8;
  localparam int MULT_W    = 29;
  localparam int RECIP_SH  = 32;
  localparam int PROD_W    = HUE_W + MULT_W;
  localparam int QUOT_W    = PROD_W - RECIP_SH;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  // channel slots in the spec vector
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_LIME  = 3;
  localparam int CH_AMBER = 4;
  localparam int CH_CYAN  = 5;

  // region upper bounds on the high hue byte, inclusive
  localparam logic [7:0] BOUND_0 = 8'd18;
  localparam logic [7:0] BOUND_1 = 8'd39;
  localparam logic [7:0] BOUND_2 = 8'd60;
  localparam logic [7:0] BOUND_3 = 8'd81;
  localparam logic [7:0] BOUND_4 = 8'd97;
  localparam logic [7:0] BOUND_5 = 8'd123;
  localparam logic [7:0] BOUND_6 = 8'd162;
  localparam logic [7:0] BOUND_7 = 8'd173;
  localparam logic [7:0] BOUND_8 = 8'd214;

  // ramp offsets
  localparam logic [HUE_W-1:0] OFS_ZERO   = 16'd0;
  localparam logic [HUE_W-1:0] OFS_4864   = 16'd4864;
  localparam logic [HUE_W-1:0] OFS_9984   = 16'd9984;
  localparam logic [HUE_W-1:0] OFS_10240  = 16'd10240;
  localparam logic [HUE_W-1:0] OFS_15615  = 16'd15615;
  localparam logic [HUE_W-1:0] OFS_20991  = 16'd20991;
  localparam logic [HUE_W-1:0] OFS_20992  = 16'd20992;
  localparam logic [HUE_W-1:0] OFS_25088  = 16'd25088;
  localparam logic [HUE_W-1:0] OFS_41727  = 16'd41727;
  localparam logic [HUE_W-1:0] OFS_44543  = 16'd44543;
  localparam logic [HUE_W-1:0] OFS_44544  = 16'd44544;
  localparam logic [HUE_W-1:0] OFS_44790  = 16'd44790;
  localparam logic [HUE_W-1:0] OFS_65535  = 16'd65535;

  // ceil(k * 2^32 / div): exact floor(k*d/div) for any 16-bit d since d*err < 2^32
  localparam logic [MULT_W-1:0] M_255_4863  =
    MULT_W'(((64'd255 << RECIP_SH) + 64'd4862) / 64'd4863);
  localparam logic [MULT_W-1:0] M_255_5375  =
    MULT_W'(((64'd255 << RECIP_SH) + 64'd5374) / 64'd5375);
  localparam logic [MULT_W-1:0] M_255_3839  =
    MULT_W'(((64'd255 << RECIP_SH) + 64'd3838) / 64'd3839);
  localparam logic [MULT_W-1:0] M_255_6399  =
    MULT_W'(((64'd255 << RECIP_SH) + 64'd6398) / 64'd6399);
  localparam logic [MULT_W-1:0] M_255_9983  =
    MULT_W'(((64'd255 << RECIP_SH) + 64'd9982) / 64'd9983);
  localparam logic [MULT_W-1:0] M_51_2600   =
    MULT_W'(((64'd51 << RECIP_SH) + 64'd2599) / 64'd2600);
  localparam logic [MULT_W-1:0] M_60_2815   =
    MULT_W'(((64'd60 << RECIP_SH) + 64'd2814) / 64'd2815);
  localparam logic [MULT_W-1:0] M_255_10239 =
    MULT_W'(((64'd255 << RECIP_SH) + 64'd10238) / 64'd10239);
  localparam logic [MULT_W-1:0] M_255_10495 =
    MULT_W'(((64'd255 << RECIP_SH) + 64'd10494) / 64'd10495);

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_FULL = 2'd1,
    MODE_UP   = 2'd2,
    MODE_DOWN = 2'd3
  } ch_mode_t;

  typedef struct packed {
    ch_mode_t                mode;
    logic [HUE_W-1:0]  offset;
    logic [MULT_W-1:0] mult;
  } ch_spec_t;

  typedef ch_spec_t [NUM_CH-1:0] mix_spec_t;

  typedef enum logic [3:0] {
    REGION_0 = 4'd0,
    REGION_1 = 4'd1,
    REGION_2 = 4'd2,
    REGION_3 = 4'd3,
    REGION_4 = 4'd4,
    REGION_5 = 4'd5,
    REGION_6 = 4'd6,
    REGION_7 = 4'd7,
    REGION_8 = 4'd8,
    REGION_9 = 4'd9
  } region_t;

  localparam ch_spec_t SPEC_OFF  = '{mode: MODE_OFF,  offset: OFS_ZERO, mult: '0};
  localparam ch_spec_t SPEC_FULL = '{mode: MODE_FULL, offset: OFS_ZERO, mult: '0};

  function automatic region_t hue_region(input logic [7:0] hh);
    region_t r;
    priority if (hh <= BOUND_0) r = REGION_0;
    else if (hh <= BOUND_1)     r = REGION_1;
    else if (hh <= BOUND_2)     r = REGION_2;
    else if (hh <= BOUND_3)     r = REGION_3;
    else if (hh <= BOUND_4)     r = REGION_4;
    else if (hh <= BOUND_5)     r = REGION_5;
    else if (hh <= BOUND_6)     r = REGION_6;
    else if (hh <= BOUND_7)     r = REGION_7;
    else if (hh <= BOUND_8)     r = REGION_8;
    else                        r = REGION_9;
    return r;
  endfunction

  function automatic mix_spec_t region_spec(input region_t r);
    mix_spec_t s;
    s = {NUM_CH{SPEC_OFF}};
    unique case (r)
      REGION_0: begin
        s[CH_RED]   = SPEC_FULL;
        s[CH_AMBER] = '{mode: MODE_UP, offset: OFS_ZERO, mult: M_255_4863};
      end
      REGION_1: begin
        s[CH_RED]   = '{mode: MODE_DOWN, offset: OFS_9984, mult: M_255_5375};
        s[CH_LIME]  = '{mode: MODE_UP, offset: OFS_4864, mult: M_255_5375};
        s[CH_AMBER] = SPEC_FULL;
      end
      REGION_2: begin
        s[CH_GREEN] = '{mode: MODE_UP, offset: OFS_10240, mult: M_255_5375};
        s[CH_LIME]  = SPEC_FULL;
        s[CH_AMBER] = '{mode: MODE_DOWN, offset: OFS_15615, mult: M_255_5375};
      end
      REGION_3: begin
        s[CH_GREEN] = SPEC_FULL;
        s[CH_LIME]  = '{mode: MODE_DOWN, offset: OFS_20991, mult: M_255_5375};
      end
      REGION_4: begin
        s[CH_GREEN] = SPEC_FULL;
        s[CH_CYAN]  = '{mode: MODE_UP, offset: OFS_20992, mult: M_255_3839};
      end
      REGION_5: begin
        s[CH_GREEN] = SPEC_FULL;
        s[CH_BLUE]  = '{mode: MODE_UP, offset: OFS_25088, mult: M_255_6399};
        s[CH_CYAN]  = SPEC_FULL;
      end
      REGION_6: begin
        s[CH_GREEN] = '{mode: MODE_DOWN, offset: OFS_41727, mult: M_255_9983};
        s[CH_BLUE]  = SPEC_FULL;
        s[CH_CYAN]  = '{mode: MODE_DOWN, offset: OFS_44790, mult: M_51_2600};
      end
      REGION_7: begin
        s[CH_BLUE]  = SPEC_FULL;
        s[CH_CYAN]  = '{mode: MODE_DOWN, offset: OFS_44543, mult: M_60_2815};
      end
      REGION_8: begin
        s[CH_RED]   = '{mode: MODE_UP, offset: OFS_44544, mult: M_255_10239};
        s[CH_BLUE]  = SPEC_FULL;
      end
      REGION_9: begin
        s[CH_RED]   = SPEC_FULL;
        s[CH_BLUE]  = '{mode: MODE_DOWN, offset: OFS_65535, mult: M_255_10495};
      end
      default: s = {NUM_CH{SPEC_OFF}};
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/hsem_in_if.sv
// hsem_in_if: hue input channel, valid/ready with high and low hue bytes
// no dependencies
interface hsem_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue_high;
  logic [7:0] hue_low;

  modport source (output valid, output hue_high, output hue_low, input ready);
  modport sink (input valid, input hue_high, input hue_low, output ready);
endinterface

// File: rtl/core/hsem_out_if.sv
// hsem_out_if: emitter level output channel, valid/ready with six drive levels
// no dependencies
interface hsem_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;
  logic [7:0] lime_level;
  logic [7:0] amber_level;
  logic [7:0] cyan_level;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  output lime_level, output amber_level, output cyan_level, input ready);
  modport sink (input valid, input red_level, input green_level, input blue_level,
                input lime_level, input amber_level, input cyan_level, output ready);
endinterface

// File: rtl/core/hsem_ramp.sv
// hsem_ramp: one emitter channel, off / full / rising or falling ramp with clamp
// depends on hsem_pkg
module hsem_ramp
  import hsem_pkg::*;
(
  input  logic [HUE_W-1:0]   hue,
  input  ch_spec_t           spec,
  output logic [LEVEL_W-1:0] level
);

  logic [HUE_W:0]    diff;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;

  always_comb begin
    if (spec.mode == MODE_DOWN) begin
      diff = {1'b0, spec.offset} - {1'b0, hue};
    end else begin
      diff = {1'b0, hue} - {1'b0, spec.offset};
    end
  end

  // reciprocal multiply, the quotient sits above the fraction bits
  assign prod = PROD_W'(diff[HUE_W-1:0]) * PROD_W'(spec.mult);
  assign quot = prod[PROD_W-1:RECIP_SH];

  always_comb begin
    unique case (spec.mode)
      MODE_OFF:  level = '0;
      MODE_FULL: level = LEVEL_MAX;
      MODE_UP, MODE_DOWN: begin
        // difference at or below zero gives dark, overflow clamps
        if (diff[HUE_W] || diff == '0) begin
          level = '0;
        end else if (quot > QUOT_W'(LEVEL_MAX)) begin
          level = LEVEL_MAX;
        end else begin
          level = quot[LEVEL_W-1:0];
        end
      end
      default: level = '0;
    endcase
  end

endmodule

// File: rtl/core/hue_to_six_emitter_mix.sv
// hue_to_six_emitter_mix: top level, input register, region decode, six ramps, result register
// depends on hsem_pkg, hsem_in_if, hsem_out_if, hsem_ramp

// Maps a 16-bit hue (high byte selects one of ten regions, low byte the position inside it)
// to red, green, blue, lime, amber and cyan drive levels. One beat is accepted every clock
// while results are taken. A taken hue beat waits in the input register and moves on to the
// result register when the result side can take it. Between those two registers lie the
// region decode and one 16x29 constant multiply per channel. The two
// registers hold up to two beats, so a stalled result stops new hue beats only once the input
// register is also full.
module hue_to_six_emitter_mix
  import hsem_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  hsem_in_if.sink    hue,
  hsem_out_if.source mix
);

  logic              hue_valid;
  logic [HUE_W-1:0]  hue_word;
  logic              mix_valid;
  logic [LEVEL_W-1:0] levels [NUM_CH];
  logic [LEVEL_W-1:0] levels_next [NUM_CH];
  logic              stage_ready;
  mix_spec_t         spec;

  assign stage_ready = !mix_valid || mix.ready;
  assign hue.ready   = !hue_valid || stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_valid <= 1'b0;
    end else if (hue.ready) begin
      hue_valid <= hue.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hue.ready && hue.valid) begin
      hue_word <= {hue.hue_high, hue.hue_low};
    end
  end

  assign spec = region_spec(hue_region(hue_word[HUE_W-1:HUE_W-8]));

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    hsem_ramp u_ramp (
      .hue   (hue_word),
      .spec  (spec[c]),
      .level (levels_next[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else if (stage_ready) begin
      mix_valid <= hue_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && hue_valid) begin
      levels <= levels_next;
    end
  end

  assign mix.valid       = mix_valid;
  assign mix.red_level   = levels[CH_RED];
  assign mix.green_level = levels[CH_GREEN];
  assign mix.blue_level  = levels[CH_BLUE];
  assign mix.lime_level  = levels[CH_LIME];
  assign mix.amber_level = levels[CH_AMBER];
  assign mix.cyan_level  = levels[CH_CYAN];

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    hue.valid && hue.ready |=> hue_valid)
    else $error("accepted hue beat did not reach the input register");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    hue_valid && stage_ready |=> mix_valid)
    else $error("input register advanced but no result is held");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    hue_valid && !stage_ready |=> hue_valid && $stable(hue_word))
    else $error("input register changed while the result side stalled");

  // every region holds at least one emitter at full drive
  a_one_full: assert property (@(posedge clk) disable iff (rst)
    mix.valid |-> (mix.red_level == LEVEL_MAX || mix.green_level == LEVEL_MAX ||
                   mix.blue_level == LEVEL_MAX || mix.lime_level == LEVEL_MAX ||
                   mix.amber_level == LEVEL_MAX || mix.cyan_level == LEVEL_MAX))
    else $error("result beat has no channel at full drive");

endmodule
